// ===== rtl/rdsm_pkg.sv =====
// Shared types, constants and helpers for the regex dot-star matcher.
`timescale 1ns / 1ps

package rdsm_pkg;

	localparam int MAX_PATTERN = 32;
	localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
	localparam int SYM_W       = 8;

	localparam logic [SYM_W-1:0] SYM_ANY  = 8'd46;
	localparam logic [SYM_W-1:0] SYM_STAR = 8'd42;

	typedef enum logic [1:0] {
		OP_PATTERN = 2'd0,
		OP_TEXT    = 2'd1,
		OP_REPORT  = 2'd2
	} op_t;

	// Row command broadcast to every cell.
	typedef struct packed {
		logic             step;  // update the match bits this cycle
		logic             adv;   // 1: advance on a text byte, 0: re-seed
		logic [SYM_W-1:0] sym;   // text byte
	} row_cmd_t;

	function automatic logic elem_match(input logic [SYM_W-1:0] e, input logic [SYM_W-1:0] c);
		return (e == SYM_ANY) || (e == c);
	endfunction

endpackage

// ===== rtl/regex_dot_star_matcher.sv =====
// Top level of the regex dot-star matcher: control, row of cells and result register.
// Text bytes: one per cycle unless stalled, the whole row updates in the cycle of the transfer.
// Report: matched is valid in the cycle after the report transfer; the row re-seeds on that transfer.
// Final pattern byte: the row re-seeds in the cycle after, input stalled meanwhile.
// The single row of cells steps on text and report transfers and on a re-seed. Reset (arst_n low)
// clears length, cell bits and out_valid, sets row bit 0; pattern bytes are undefined until written.
`timescale 1ns / 1ps

module regex_dot_star_matcher import rdsm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [1:0]       operation,
	input  logic [4:0]       position,
	input  logic [SYM_W-1:0] symbol,
	input  logic             last,
	output logic             out_valid,
	input  logic             out_stall,
	output logic             matched
);

	logic                 accept;
	logic                 is_report;
	logic                 wr;
	logic                 seed_pend_q;
	logic [LEN_W-1:0]     len_q;
	logic                 out_valid_q;
	logic                 matched_q;
	logic [MAX_PATTERN:0] row_bits;
	row_cmd_t             cmd;

	// A report needs the result register free; all input stalls while a re-seed is pending.
	assign is_report = (operation == OP_REPORT);
	assign in_stall  = seed_pend_q || (out_valid_q && out_stall && is_report);
	assign accept    = in_valid && !in_stall;

	// Pattern writes beyond the store are dropped.
	assign wr = accept && (operation == OP_PATTERN) && (int'(position) < MAX_PATTERN);

	// Row command: advance on a text byte, re-seed after a report or a final
	// pattern byte (the latter in the following cycle so it sees the byte just written).
	always_comb begin
		cmd.sym  = symbol;
		cmd.step = seed_pend_q || (accept && (operation == OP_TEXT || is_report));
		cmd.adv  = !seed_pend_q && (operation == OP_TEXT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= '0;
			seed_pend_q <= 1'b0;
		end else begin
			seed_pend_q <= wr && last;
			if (wr && last) begin
				len_q <= LEN_W'(position) + LEN_W'(1);
			end
		end
	end

	rdsm_row u_row (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.wr       (wr),
		.wr_pos   (position),
		.wr_sym   (symbol),
		.len      (len_q),
		.row_bits (row_bits)
	);

	// Result register: holds matched until the downstream transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && is_report) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_report) begin
			matched_q <= row_bits[len_q];
		end
	end

	assign out_valid = out_valid_q;
	assign matched   = matched_q;

endmodule

// ===== rtl/rdsm_cell.sv =====
// One matcher cell: a pattern byte and the match bit of the prefix ending on it.
`timescale 1ns / 1ps

module rdsm_cell import rdsm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  row_cmd_t         cmd,
	input  logic             wr_en,
	input  logic [SYM_W-1:0] wr_sym,
	input  logic             active,
	input  logic             has_prev,
	input  logic [SYM_W-1:0] prev_pat,
	input  logic             old_prev,
	input  logic             chain_in,
	output logic [SYM_W-1:0] pat,
	output logic             bit_out,
	output logic             nxt
);

	logic [SYM_W-1:0] pat_q;
	logic             bit_q;
	logic             star;
	logic             rep_hit;
	logic             lit_hit;

	// A star repeats the element before it; in front position it is a literal.
	assign star    = has_prev && (pat_q == SYM_STAR);
	assign rep_hit = cmd.adv && bit_q && elem_match(prev_pat, cmd.sym);
	assign lit_hit = cmd.adv && old_prev && elem_match(pat_q, cmd.sym);

	always_comb begin
		if (!active) begin
			nxt = 1'b0;
		end else if (star) begin
			nxt = chain_in || rep_hit;
		end else begin
			nxt = lit_hit;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			pat_q <= wr_sym;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q <= 1'b0;
		end else if (cmd.step) begin
			bit_q <= nxt;
		end
	end

	assign pat     = pat_q;
	assign bit_out = bit_q;

endmodule

// ===== rtl/rdsm_row.sv =====
// Row of matcher cells plus the empty-prefix bit.
`timescale 1ns / 1ps

module rdsm_row import rdsm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  row_cmd_t             cmd,
	input  logic                 wr,
	input  logic [4:0]           wr_pos,
	input  logic [SYM_W-1:0]     wr_sym,
	input  logic [LEN_W-1:0]     len,
	output logic [MAX_PATTERN:0] row_bits
);

	logic [SYM_W-1:0]       pats  [MAX_PATTERN];
	logic [MAX_PATTERN-1:0] bits;
	logic [MAX_PATTERN-1:0] nxts;
	logic                   row0_q;
	logic                   row0_nxt;

	// Empty prefix: set on a re-seed, cleared once any text byte is taken.
	assign row0_nxt = !cmd.adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row0_q <= 1'b1;
		end else if (cmd.step) begin
			row0_q <= row0_nxt;
		end
	end

	for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
		logic             wr_en;
		logic             active;
		logic [SYM_W-1:0] prev_pat;
		logic             old_prev;
		logic             chain_in;

		assign wr_en  = wr && (int'(wr_pos) == j);
		assign active = len > LEN_W'(j);

		if (j == 0) begin : g_first
			assign prev_pat = '0;
			assign old_prev = row0_q;
			assign chain_in = 1'b0;
		end else if (j == 1) begin : g_second
			assign prev_pat = pats[j-1];
			assign old_prev = bits[j-1];
			assign chain_in = row0_nxt;
		end else begin : g_rest
			assign prev_pat = pats[j-1];
			assign old_prev = bits[j-1];
			assign chain_in = nxts[j-2];
		end

		rdsm_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmd      (cmd),
			.wr_en    (wr_en),
			.wr_sym   (wr_sym),
			.active   (active),
			.has_prev (j != 0),
			.prev_pat (prev_pat),
			.old_prev (old_prev),
			.chain_in (chain_in),
			.pat      (pats[j]),
			.bit_out  (bits[j]),
			.nxt      (nxts[j])
		);
	end

	assign row_bits = {bits, row0_q};

endmodule
